// ===== src/smtx_pkg.sv =====
`timescale 1ns / 1ps

package smtx_pkg;

  // Event codes on the input mode field
  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_BIT    = 3'd2;
  localparam logic [2:0] MODE_CLK_HI = 3'd3;
  localparam logic [2:0] MODE_CLK_LO = 3'd4;

  // Bits per byte and the reload value of the bit counter
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    LINK_IDLE = 2'd0,
    LINK_INIT = 2'd1,
    LINK_RUN  = 2'd2,
    LINK_DOWN = 2'd3
  } link_state_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_START  = 3'd1,
    OP_BIT    = 3'd2,
    OP_CLK_HI = 3'd3,
    OP_CLK_LO = 3'd4,
    OP_NONE   = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic       mosi;
    logic       sclk;
    logic [1:0] link_state;
    logic [3:0] fifo_level;
    logic [7:0] overflow_count;
    logic [7:0] bytes_sent;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== src/smtx_front.sv =====
`timescale 1ns / 1ps

module smtx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smtx_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output smtx_pkg::cmd_t    cmd
);

  smtx_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  smtx_pkg::cmd_t dec;
  logic           push;
  logic           pop;

  // Classify the incoming event
  always_comb begin
    dec.data = in_item.byte_in;
    unique case (in_item.mode)
      smtx_pkg::MODE_PUSH:   dec.op = smtx_pkg::OP_PUSH;
      smtx_pkg::MODE_START:  dec.op = smtx_pkg::OP_START;
      smtx_pkg::MODE_BIT:    dec.op = smtx_pkg::OP_BIT;
      smtx_pkg::MODE_CLK_HI: dec.op = smtx_pkg::OP_CLK_HI;
      smtx_pkg::MODE_CLK_LO: dec.op = smtx_pkg::OP_CLK_LO;
      default:               dec.op = smtx_pkg::OP_NONE;
    endcase
  end

  // Two-entry command queue between front and back
  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== src/smtx_back.sv =====
`timescale 1ns / 1ps

module smtx_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  smtx_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output smtx_pkg::out_item_t out_item
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = PTR_W + 1;
  localparam int EXT_W = (LVL_W > 4) ? LVL_W : 4;

  logic [7:0]             mem [FIFO_DEPTH];
  logic [7:0]             rd_q_r;

  logic [PTR_W-1:0]       rp_r, rp_nxt, rp_inc;
  logic [PTR_W-1:0]       wp_r, wp_nxt, wp_inc;
  logic [7:0]             sr_r, sr_nxt, sr_sel;
  logic [3:0]             bc_r, bc_nxt;
  smtx_pkg::link_state_t  phase_r, phase_nxt;
  logic [7:0]             rej_r, rej_nxt;
  logic [7:0]             sent_r, sent_nxt;
  logic                   mosi_r, mosi_nxt;
  logic                   sclk_r, sclk_nxt;
  logic                   empty, full;
  logic                   mem_we;
  logic                   pop;
  logic                   out_valid_r, out_valid_nxt;
  smtx_pkg::out_item_t    out_item_r, res;
  logic [LVL_W-1:0]       lvl;
  logic [EXT_W-1:0]       lvl_ext;

  // Take a command whenever the output slot is free or being drained
  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign rp_inc = (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wp_inc = (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign empty  = (rp_r == wp_r);
  assign full   = (wp_inc == rp_r);

  // Execute the event: next state of the link and counters
  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    sr_nxt    = sr_r;
    bc_nxt    = bc_r;
    phase_nxt = phase_r;
    rej_nxt   = rej_r;
    sent_nxt  = sent_r;
    mosi_nxt  = mosi_r;
    sclk_nxt  = sclk_r;
    mem_we    = 1'b0;
    sr_sel    = sr_r;
    if (pop) begin
      unique case (cmd.op)
        smtx_pkg::OP_PUSH: begin
          if (full) begin
            rej_nxt = rej_r + 8'd1;
          end else begin
            mem_we = 1'b1;
            wp_nxt = wp_inc;
          end
        end
        smtx_pkg::OP_START: begin
          if (!empty && phase_r == smtx_pkg::LINK_IDLE) begin
            bc_nxt    = smtx_pkg::BITS_PER_BYTE;
            phase_nxt = smtx_pkg::LINK_INIT;
          end
        end
        smtx_pkg::OP_BIT: begin
          if (phase_r == smtx_pkg::LINK_INIT || phase_r == smtx_pkg::LINK_RUN) begin
            if (bc_r == smtx_pkg::BITS_PER_BYTE && empty) begin
              phase_nxt = smtx_pkg::LINK_DOWN;
            end else begin
              if (bc_r == smtx_pkg::BITS_PER_BYTE) begin
                sr_sel   = rd_q_r;
                sent_nxt = sent_r + 8'd1;
                rp_nxt   = rp_inc;
                bc_nxt   = 4'd1;
              end else begin
                bc_nxt = bc_r + 4'd1;
              end
              mosi_nxt  = sr_sel[7];
              sr_nxt    = {sr_sel[6:0], 1'b0};
              phase_nxt = smtx_pkg::LINK_RUN;
            end
          end
        end
        smtx_pkg::OP_CLK_HI: begin
          sclk_nxt = (phase_r == smtx_pkg::LINK_RUN || phase_r == smtx_pkg::LINK_DOWN);
        end
        smtx_pkg::OP_CLK_LO: begin
          sclk_nxt = 1'b0;
          if (phase_r == smtx_pkg::LINK_DOWN) begin
            phase_nxt = smtx_pkg::LINK_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status after the event
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      lvl = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      lvl = {1'b0, wp_nxt} + LVL_W'(FIFO_DEPTH) - {1'b0, rp_nxt};
    end
    lvl_ext            = EXT_W'(lvl);
    res.mosi           = mosi_nxt;
    res.sclk           = sclk_nxt;
    res.link_state     = phase_nxt;
    res.fifo_level     = lvl_ext[3:0];
    res.overflow_count = rej_nxt;
    res.bytes_sent     = sent_nxt;
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      sr_r        <= 8'd0;
      bc_r        <= 4'd0;
      phase_r     <= smtx_pkg::LINK_IDLE;
      rej_r       <= 8'd0;
      sent_r      <= 8'd0;
      mosi_r      <= 1'b0;
      sclk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      sr_r        <= sr_nxt;
      bc_r        <= bc_nxt;
      phase_r     <= phase_nxt;
      rej_r       <= rej_nxt;
      sent_r      <= sent_nxt;
      mosi_r      <= mosi_nxt;
      sclk_r      <= sclk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register on each executed transaction
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= res;
    end
  end

  // Write the byte store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= cmd.data;
    end
  end

  // Prefetch the head entry; bypass a write to the same address
  always_ff @(posedge clk) begin
    if (mem_we && wp_r == rp_nxt) begin
      rd_q_r <= cmd.data;
    end else begin
      rd_q_r <= mem[rp_nxt];
    end
  end

  a_bc_range: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= smtx_pkg::BITS_PER_BYTE)
    else $error("bit counter beyond one byte");

  a_run_bc: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == smtx_pkg::LINK_RUN |-> bc_r != 4'd0)
    else $error("link running with no bit sent");

  a_push_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.op == smtx_pkg::OP_PUSH && !full) |=> wp_r == $past(wp_inc))
    else $error("accepted push did not advance write pointer");

  a_sent_src: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && cmd.op == smtx_pkg::OP_BIT) |=> $stable(sent_r) && $stable(rp_r))
    else $error("byte popped outside a bit tick");

endmodule

// ===== src/spi_master_tx_serializer_core.sv =====
`timescale 1ns / 1ps

// SPI master transmit serializer, mode 0, MSB first.
// Input channel (in_valid/in_ready/in_item) carries one event per transaction:
// push a byte into the transmit ring buffer, start a transfer, or one of the
// three timer phases (bit tick drives MOSI, clock-high raises SCLK, clock-low
// lowers SCLK and closes a teardown). The buffer holds FIFO_DEPTH-1 bytes;
// pushes into a full buffer are dropped and counted.
// Output channel (out_valid/out_ready/out_item) returns exactly one status
// transaction per event: line levels, link state, buffer level and the
// overflow and sent-byte counters as they stand after that event.
// An accepted event waits in the command queue, is executed by the back end,
// and its status is loaded into the result register that drives out_item.
// Throughput: one event per cycle while out_ready stays high; the byte store
// is one write port and one registered read port kept loaded with the head
// entry.
// A two-entry command queue sits between the decode front and the execute
// back; when the receiver stalls, the result register holds, the queue
// fills and in_ready drops after two more events.
// Reset (rst_n low, synchronous) empties the buffer and queue, zeroes the
// counters and lines and puts the link in idle; no result is pending.
module spi_master_tx_serializer_core #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smtx_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output smtx_pkg::out_item_t out_item
);

  logic           cmd_valid;
  logic           cmd_ready;
  smtx_pkg::cmd_t cmd;

  // Decode and queue events
  smtx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Execute events and report status
  smtx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== dv/spi_master_tx_serializer_core_tb.sv =====
`timescale 1ns / 1ps

module spi_master_tx_serializer_core_tb;

  localparam int          FIFO_DEPTH     = 16;
  localparam int unsigned RANDOM_EVENTS  = 900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned NO_IDLE_FROM   = 500;
  localparam int unsigned NO_IDLE_TO     = 650;

  // Mode codes that the block decodes to no operation
  localparam logic [2:0] MODE_SPARE0 = 3'd5;
  localparam logic [2:0] MODE_SPARE1 = 3'd6;
  localparam logic [2:0] MODE_SPARE2 = 3'd7;

  typedef struct packed {
    smtx_pkg::in_item_t  ev;
    logic                typed;
    smtx_pkg::out_item_t status;
  } stim_row_t;

  localparam smtx_pkg::out_item_t IDLE_STATUS = '0;
  localparam smtx_pkg::out_item_t ONE_QUEUED  =
    '{1'b0, 1'b0, smtx_pkg::LINK_IDLE, 4'd1, 8'd0, 8'd0};

  // Opening sequence: no-op modes and idle-link events first, then a short transfer
  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{MODE_SPARE2,           8'hFF}, 1'b1, IDLE_STATUS},
    '{'{smtx_pkg::MODE_START,  8'h00}, 1'b1, IDLE_STATUS},
    '{'{smtx_pkg::MODE_BIT,    8'h00}, 1'b1, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_HI, 8'h00}, 1'b1, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_LO, 8'hFF}, 1'b1, IDLE_STATUS},
    '{'{smtx_pkg::MODE_PUSH,   8'hA5}, 1'b1, ONE_QUEUED},
    '{'{smtx_pkg::MODE_PUSH,   8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_PUSH,   8'hFF}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_PUSH,   8'h5A}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_START,  8'hFF}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_HI, 8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_BIT,    8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_START,  8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_HI, 8'hFF}, 1'b0, IDLE_STATUS},
    '{'{MODE_SPARE0,           8'h3C}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_LO, 8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_BIT,    8'hFF}, 1'b0, IDLE_STATUS},
    '{'{MODE_SPARE1,           8'hC3}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_PUSH,   8'h80}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_BIT,    8'h01}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_HI, 8'h00}, 1'b0, IDLE_STATUS},
    '{'{smtx_pkg::MODE_CLK_LO, 8'h00}, 1'b0, IDLE_STATUS}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  smtx_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  smtx_pkg::out_item_t out_item;

  // Shadow of the serializer state
  logic [7:0]            fifo_mem [FIFO_DEPTH];
  logic [3:0]            rd_ptr;
  logic [3:0]            wr_ptr;
  logic [7:0]            shreg;
  logic [3:0]            bit_cnt;
  smtx_pkg::link_state_t pred_link;
  logic [7:0]            rejects;
  logic [7:0]            sent;
  logic                  mosi_q;
  logic                  sclk_q;

  smtx_pkg::out_item_t status_q [$];
  logic                row_typed;
  smtx_pkg::out_item_t row_status;
  int unsigned         fail_count;
  int unsigned         events_sent;
  int unsigned         idle_cycles;
  int unsigned         hold_left;
  bit                  hold_req;
  bit                  no_idle;

  spi_master_tx_serializer_core #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Apply one event to the shadow state and return the status it leaves behind
  function automatic smtx_pkg::out_item_t serialize_event(smtx_pkg::in_item_t ev);
    smtx_pkg::out_item_t st;
    case (ev.mode)
      smtx_pkg::MODE_PUSH: begin
        if (4'(wr_ptr + 1) == rd_ptr) begin
          rejects = rejects + 8'd1;
        end else begin
          fifo_mem[wr_ptr] = ev.byte_in;
          wr_ptr = 4'(wr_ptr + 1);
        end
      end
      smtx_pkg::MODE_START: begin
        if (rd_ptr != wr_ptr && pred_link == smtx_pkg::LINK_IDLE) begin
          bit_cnt = smtx_pkg::BITS_PER_BYTE;
          pred_link = smtx_pkg::LINK_INIT;
        end
      end
      smtx_pkg::MODE_BIT: begin
        if (pred_link == smtx_pkg::LINK_INIT || pred_link == smtx_pkg::LINK_RUN) begin
          if (bit_cnt == smtx_pkg::BITS_PER_BYTE && rd_ptr == wr_ptr) begin
            // nothing left to send: close the link, keep MOSI
            pred_link = smtx_pkg::LINK_DOWN;
          end else begin
            if (bit_cnt == smtx_pkg::BITS_PER_BYTE) begin
              sent = sent + 8'd1;
              bit_cnt = '0;
              shreg = fifo_mem[rd_ptr];
              rd_ptr = 4'(rd_ptr + 1);
            end
            mosi_q = shreg[7];
            shreg = {shreg[6:0], 1'b0};
            bit_cnt = 4'(bit_cnt + 1);
            pred_link = smtx_pkg::LINK_RUN;
          end
        end
      end
      smtx_pkg::MODE_CLK_HI:
        sclk_q = (pred_link == smtx_pkg::LINK_RUN || pred_link == smtx_pkg::LINK_DOWN);
      smtx_pkg::MODE_CLK_LO: begin
        sclk_q = 1'b0;
        if (pred_link == smtx_pkg::LINK_DOWN) pred_link = smtx_pkg::LINK_IDLE;
      end
      default: ;
    endcase
    st.mosi           = mosi_q;
    st.sclk           = sclk_q;
    st.link_state     = pred_link;
    st.fifo_level     = 4'(wr_ptr - rd_ptr);
    st.overflow_count = rejects;
    st.bytes_sent     = sent;
    return st;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // Check each returned status, then predict the transaction accepted at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr    = '0;
      wr_ptr    = '0;
      shreg     = '0;
      bit_cnt   = '0;
      pred_link = smtx_pkg::LINK_IDLE;
      rejects   = '0;
      sent      = '0;
      mosi_q    = 1'b0;
      sclk_q    = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: status with none expected, actual %h", $time, out_item);
          fail_count++;
        end else begin
          smtx_pkg::out_item_t want;
          want = status_q.pop_front();
          check_field("mosi", want.mosi, out_item.mosi);
          check_field("sclk", want.sclk, out_item.sclk);
          check_field("link_state", want.link_state, out_item.link_state);
          check_field("fifo_level", want.fifo_level, out_item.fifo_level);
          check_field("overflow_count", want.overflow_count, out_item.overflow_count);
          check_field("bytes_sent", want.bytes_sent, out_item.bytes_sent);
        end
      end
      if (in_valid && in_ready) begin
        smtx_pkg::out_item_t predicted;
        predicted = serialize_event(in_item);
        status_q.push_back(row_typed ? row_status : predicted);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[spi_master_tx_serializer_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  // Offer one transaction; entered and left at a falling edge
  task automatic send_event(smtx_pkg::in_item_t ev, logic typed = 1'b0,
                            smtx_pkg::out_item_t status = '0);
    no_idle = (events_sent >= NO_IDLE_FROM && events_sent < NO_IDLE_TO);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_item    <= ev;
    row_typed  = typed;
    row_status = status;
    do @(posedge clk); while (!in_ready);
    events_sent++;
    @(negedge clk);
  endtask

  function automatic smtx_pkg::in_item_t rand_event(logic [2:0] mode);
    smtx_pkg::in_item_t ev;
    ev.mode    = mode;
    ev.byte_in = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  // Timer phase with the odd stray event mixed in
  task automatic send_phase(logic [2:0] mode);
    if ($urandom_range(99) < 6) begin
      send_event(rand_event(3'($urandom_range(0, 7))));
    end else begin
      send_event(rand_event(mode));
    end
  endtask

  // Queue bytes, start, and tick the link until it is idle again
  task automatic run_transfer(int unsigned nbytes);
    int unsigned guard;
    guard = 0;
    repeat (nbytes) send_event(rand_event(smtx_pkg::MODE_PUSH));
    send_event(rand_event(smtx_pkg::MODE_START));
    while (pred_link != smtx_pkg::LINK_IDLE && guard < 1000) begin
      guard++;
      if ($urandom_range(99) < 5) send_event(rand_event(smtx_pkg::MODE_PUSH));
      send_phase(smtx_pkg::MODE_BIT);
      send_phase(smtx_pkg::MODE_CLK_HI);
      send_phase(smtx_pkg::MODE_CLK_LO);
    end
  endtask

  // Drop valid and let every outstanding status come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (status_q.size() != 0);
  endtask

  initial begin
    int unsigned pick;
    bit          hold_done;
    bit          pause_done;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_ready   = 1'b0;
    row_typed   = 1'b0;
    row_status  = '0;
    fail_count  = 0;
    events_sent = 0;
    idle_cycles = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    no_idle     = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].status);
    end
    wait_drained();

    // Random part: mostly complete transfers, some floods and noise
    while (events_sent < DIRECTED_ROWS + RANDOM_EVENTS) begin
      if (!hold_done && events_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && events_sent > 700) begin
        wait_drained();
        pause_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_transfer(($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(4, 15));
      end else if (pick < 76) begin
        // overfill the buffer so pushes get rejected, then drain it
        repeat ($urandom_range(16, 40)) send_event(rand_event(smtx_pkg::MODE_PUSH));
        run_transfer(0);
      end else begin
        repeat ($urandom_range(1, 8)) send_event(rand_event(3'($urandom_range(0, 7))));
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[spi_master_tx_serializer_core] OK");
    end else begin
      $display("[spi_master_tx_serializer_core] ERROR");
    end
    $finish;
  end

endmodule
